@@ src/olst_pkg.sv @@
// ----------------------------------------------------------------------------
// olst_pkg
// Shared sizes, command codes, sequencer states and the records passed
// between the list sequencer, the entry RAM and the top level.
// ----------------------------------------------------------------------------
package olst_pkg;

    // list capacity and derived widths
    localparam int DEPTH      = 64;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 7;
    localparam int CNT_OUT_W  = 7;
    localparam int FPOS_W     = 6;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    // common width for comparing a position against the count
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int FPOS_EXT_W = (ADDR_W > FPOS_W) ? ADDR_W : FPOS_W;

    // command codes
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PLACE,
        S_DOWN,
        S_SCAN,
        S_RDATA
    } state_t;

    // one access to the entry RAM, write and read ports
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // finished command, before output formatting
    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_value;
        logic [ADDR_W-1:0] found_addr;
        logic [CNT_W-1:0]  count;
    } res_t;

endpackage

@@ src/olst_ram.sv @@
// ----------------------------------------------------------------------------
// olst_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olst_ram #(
    parameter int WIDTH   = 32,
    parameter int DEPTH_P = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH_P];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/olst_seq.sv @@
// ----------------------------------------------------------------------------
// olst_seq
// Command sequencer: holds the entry count, walks the entry RAM one entry
// per cycle to shift, scan or read, and flags the cycle a command finishes.
// ----------------------------------------------------------------------------
module olst_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2:0]              cmd,
    input  logic [olst_pkg::POS_W-1:0]  position,
    input  logic [olst_pkg::DATA_W-1:0] value,
    input  logic [olst_pkg::DATA_W-1:0] rdata,
    output logic                    busy,
    output olst_pkg::ram_req_t      ram_req,
    output logic                    finish,
    output olst_pkg::res_t          res
);
    import olst_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0] word_reg, word_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [ADDR_W-1:0] pos_addr;
    logic [ADDR_W-1:0] cnt_addr;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] last_addr;
    logic              not_full;

    // position and count in comparable form
    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_addr  = pos_ext[ADDR_W-1:0];
    assign cnt_addr  = count_reg[ADDR_W-1:0];
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign last_addr = cnt_m1[ADDR_W-1:0];
    assign not_full  = (count_reg != CNT_W'(DEPTH));

    assign busy = (state_reg != S_IDLE);

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
    end

    // next state, RAM access and completion
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        ram_req        = '0;
        finish         = 1'b0;
        res.status     = 1'b1;
        res.read_value = '0;
        res.found_addr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_APPEND:
                        begin
                            finish = 1'b1;
                            if (not_full)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = cnt_addr;
                                ram_req.wdata = value;
                                count_next    = count_reg + CNT_W'(1);
                                res.status    = 1'b0;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (not_full && (pos_ext <= cnt_ext))
                            begin
                                if (pos_ext == cnt_ext)
                                begin
                                    // insert at the end is an append
                                    finish        = 1'b1;
                                    ram_req.we    = 1'b1;
                                    ram_req.waddr = cnt_addr;
                                    ram_req.wdata = value;
                                    count_next    = count_reg + CNT_W'(1);
                                    res.status    = 1'b0;
                                end
                                else
                                begin
                                    // shift up from the top entry down to pos
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = last_addr;
                                    addr_next     = last_addr;
                                    pos_next      = pos_addr;
                                    word_next     = value;
                                    state_next    = S_UP;
                                end
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                if (pos_addr == last_addr)
                                begin
                                    // removing the top entry moves nothing
                                    finish     = 1'b1;
                                    count_next = cnt_m1;
                                    res.status = 1'b0;
                                end
                                else
                                begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = pos_addr + ADDR_W'(1);
                                    addr_next     = pos_addr + ADDR_W'(1);
                                    state_next    = S_DOWN;
                                end
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                addr_next     = '0;
                                word_next     = value;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = pos_addr;
                                state_next    = S_RDATA;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused codes: rejected, nothing changes
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            // move entry addr up by one, then fetch the one below
            S_UP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_reg + ADDR_W'(1);
                ram_req.wdata = rdata;
                if (addr_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = addr_reg - ADDR_W'(1);
                    addr_next     = addr_reg - ADDR_W'(1);
                end
            end

            // drop the new word into the opened slot
            S_PLACE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = word_reg;
                count_next    = count_reg + CNT_W'(1);
                res.status    = 1'b0;
                finish        = 1'b1;
                state_next    = S_IDLE;
            end

            // move entry addr down by one, then fetch the one above
            S_DOWN:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_reg - ADDR_W'(1);
                ram_req.wdata = rdata;
                if (addr_reg == last_addr)
                begin
                    count_next = cnt_m1;
                    res.status = 1'b0;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = addr_reg + ADDR_W'(1);
                    addr_next     = addr_reg + ADDR_W'(1);
                end
            end

            // compare one entry per cycle, stop at the first match
            S_SCAN:
            begin
                if (rdata == word_reg)
                begin
                    res.status     = 1'b0;
                    res.found_addr = addr_reg;
                    finish         = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (addr_reg == last_addr)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = addr_reg + ADDR_W'(1);
                    addr_next     = addr_reg + ADDR_W'(1);
                end
            end

            S_RDATA:
            begin
                res.status     = 1'b0;
                res.read_value = rdata;
                finish         = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.count = count_next;
    end

endmodule

@@ src/ordered_array_list.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list
// Fixed-capacity ordered list of signed words held in one entry RAM.
// ----------------------------------------------------------------------------
// Append, rejects and removing the top entry finish from idle; read goes via
//   S_RDATA; insert walks S_UP down to pos, then S_PLACE; remove walks S_DOWN;
//   search walks S_SCAN. The entry RAM moves or compares one entry per cycle.
// busy is high while a command walks the RAM; the next command is taken the
//   cycle busy drops, while done shows the previous result.
// Reset clears the count; entry RAM contents are not cleared.
module ordered_array_list (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             cmd,
    input  logic [olst_pkg::POS_W-1:0]             position,
    input  logic signed [olst_pkg::DATA_W-1:0]     value,
    output logic                                   done,
    output logic                                   status,
    output logic signed [olst_pkg::DATA_W-1:0]     read_value,
    output logic [olst_pkg::FPOS_W-1:0]            found_position,
    output logic [olst_pkg::CNT_OUT_W-1:0]         entry_count,
    output logic                                   list_full,
    output logic                                   list_empty
);
    import olst_pkg::*;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] rdata;
    logic              finish;
    res_t              res;
    logic [FPOS_EXT_W-1:0] fpos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    logic              done_reg;
    logic              status_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [FPOS_W-1:0] found_position_reg;
    logic [CNT_OUT_W-1:0] entry_count_reg;
    logic              list_full_reg;
    logic              list_empty_reg;

    olst_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .position (position),
        .value    (value),
        .rdata    (rdata),
        .busy     (busy),
        .ram_req  (ram_req),
        .finish   (finish),
        .res      (res)
    );

    olst_ram #(
        .WIDTH   (DATA_W),
        .DEPTH_P (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    // fields reported as their low bits
    assign fpos_ext = FPOS_EXT_W'(res.found_addr);
    assign cnt_ext  = CMP_W'(res.count);

    // done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg         <= res.status;
            read_value_reg     <= res.read_value;
            found_position_reg <= fpos_ext[FPOS_W-1:0];
            entry_count_reg    <= cnt_ext[CNT_OUT_W-1:0];
            list_full_reg      <= (res.count == CNT_W'(DEPTH));
            list_empty_reg     <= (res.count == '0);
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign read_value     = $signed(read_value_reg);
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;
    assign list_full      = list_full_reg;
    assign list_empty     = list_empty_reg;

endmodule

@@ src/olst_chk.sv @@
// ----------------------------------------------------------------------------
// olst_chk
// Port-level checks for the ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module olst_chk (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   done,
    input logic                                   status,
    input logic signed [olst_pkg::DATA_W-1:0]     read_value,
    input logic [olst_pkg::FPOS_W-1:0]            found_position,
    input logic [olst_pkg::CNT_OUT_W-1:0]         entry_count,
    input logic                                   list_full,
    input logic                                   list_empty
);

    // an accepted item either reports next cycle or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor done");

    // the end of a walk always delivers its result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // a rejected item reports no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ((read_value == '0) && (found_position == '0)))
        else $error("rejected item carries data");

    // flags agree with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(list_full && list_empty) &&
                  (!list_empty || (entry_count == '0))))
        else $error("full/empty flags inconsistent");

endmodule

bind ordered_array_list olst_chk u_olst_chk (.*);

@@ bench/olst_list_checker.sv @@
// ----------------------------------------------------------------------------
// olst_list_checker
// Watches the command and result channels of ordered_array_list, keeps its
// own copy of the list, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module olst_list_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [2:0]                         cmd,
    input  logic [olst_pkg::POS_W-1:0]         position,
    input  logic signed [olst_pkg::DATA_W-1:0] value,
    input  logic                               done,
    input  logic                               status,
    input  logic signed [olst_pkg::DATA_W-1:0] read_value,
    input  logic [olst_pkg::FPOS_W-1:0]        found_position,
    input  logic [olst_pkg::CNT_OUT_W-1:0]     entry_count,
    input  logic                               list_full,
    input  logic                               list_empty,
    output int                                 errors,
    output int                                 outstanding
);
    import olst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 status;
        logic [DATA_W-1:0]    read_value;
        logic [FPOS_W-1:0]    found_position;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 list_full;
        logic                 list_empty;
    } list_result_t;

    // shadow copy of the list
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_len;

    list_result_t      expected_results [$];
    list_result_t      want;
    list_result_t      got;
    int                mismatch_total = 0;
    int                waiting = 0;

    assign errors      = mismatch_total;
    assign outstanding = waiting;

    // apply one command to the shadow list and return its result
    function automatic list_result_t apply_list_cmd(input logic [2:0]        op,
                                                    input logic [POS_W-1:0]  at_pos,
                                                    input logic [DATA_W-1:0] word);
        list_result_t r;
        logic         put;
        int unsigned  slot;
        r        = '0;
        r.status = 1'b1;
        put      = 1'b0;
        slot     = 0;
        case (op)
            CMD_APPEND:
                if (shadow_len < DEPTH)
                begin
                    put  = 1'b1;
                    slot = shadow_len;
                end
            CMD_INSERT:
                if (shadow_len < DEPTH && at_pos <= shadow_len)
                begin
                    put  = 1'b1;
                    slot = 32'(at_pos);
                end
            CMD_REMOVE:
                if (at_pos < shadow_len)
                begin
                    for (int unsigned i = 32'(at_pos); i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                    r.status = 1'b0;
                end
            CMD_SEARCH:
                // lowest matching position wins
                for (int unsigned i = 0; i < shadow_len; i++)
                    if (r.status && shadow_words[i] == word)
                    begin
                        r.found_position = FPOS_W'(i);
                        r.status         = 1'b0;
                    end
            CMD_READ:
                if (at_pos < shadow_len)
                begin
                    r.read_value = shadow_words[at_pos[ADDR_W-1:0]];
                    r.status     = 1'b0;
                end
            default: ;  // spare codes: rejected, no change
        endcase
        // append and insert share the shift-up path
        if (put)
        begin
            for (int unsigned i = shadow_len; i > slot; i--)
                shadow_words[i] = shadow_words[i - 1];
            shadow_words[slot] = word;
            shadow_len++;
            r.status = 1'b0;
        end
        r.entry_count = CNT_OUT_W'(shadow_len);
        r.list_full   = (shadow_len == DEPTH);
        r.list_empty  = (shadow_len == 0);
        return r;
    endfunction

    // results first (they belong to earlier items), then a new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            if (done)
            begin
                got = {status, read_value, found_position, entry_count,
                       list_full, list_empty};
                if (expected_results.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("%0t: result with nothing pending: %s",
                                 $realtime,
                                 $sformatf("st=%0b rd=%h fp=%0d cnt=%0d",
                                           status, read_value, found_position,
                                           entry_count));
                    mismatch_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_total < 10)
                        begin
                            $display("%0t: mismatch exp st=%0b rd=%h fp=%0d %s",
                                     $realtime, want.status, want.read_value,
                                     want.found_position,
                                     $sformatf("cnt=%0d full=%0b empty=%0b",
                                               want.entry_count,
                                               want.list_full, want.list_empty));
                            $display("%0t:          got st=%0b rd=%h fp=%0d %s",
                                     $realtime, got.status, got.read_value,
                                     got.found_position,
                                     $sformatf("cnt=%0d full=%0b empty=%0b",
                                               got.entry_count,
                                               got.list_full, got.list_empty));
                        end
                        mismatch_total++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_cmd(cmd, position, value));
            waiting = expected_results.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Regression for ordered_array_list: directed corner commands, then random
// traffic that repeatedly grows the list to full and drains it to empty,
// with random idle gaps on the command side. Checking is in olst_list_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import olst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;

    // command codes the block does not define
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               cmd = CMD_APPEND;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [FPOS_W-1:0]        found_position;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     list_full;
    logic                     list_empty;
    int                       errors;
    int                       outstanding;

    int                       cycles = 0;
    int                       issued [8];
    int                       n_done = 0;
    int                       n_rejected = 0;
    int                       n_full = 0;
    int                       n_empty = 0;
    int unsigned              seen_len = 0;
    logic                     no_idle = 1'b0;
    logic [DATA_W-1:0]        word_pool [8];

    ordered_array_list i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .done           (done),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .list_full      (list_full),
        .list_empty     (list_empty)
    );

    olst_list_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .done           (done),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .list_full      (list_full),
        .list_empty     (list_empty),
        .errors         (errors),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("ordered_array_list regression: fail");
            $finish;
        end
    end

    // track list length from results to steer positions; tally outcomes
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_len   <= 32'(entry_count);
            n_done     <= n_done + 1;
            n_rejected <= n_rejected + status;
            n_full     <= n_full + list_full;
            n_empty    <= n_empty + list_empty;
        end
    end

    // present one item and hold it until the block takes it
    task automatic issue(input logic [2:0] op, input logic [POS_W-1:0] at_pos,
                         input logic [DATA_W-1:0] word);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 22)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd      <= op;
        position <= at_pos;
        value    <= word;
        start    <= 1'b1;
        issued[op]++;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // often pool words so searches hit and duplicates occur
    function automatic logic [DATA_W-1:0] pick_word();
        if ($urandom_range(99) < 40)
            return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // position near the current length, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_pos(input logic for_insert);
        int unsigned top;
        int unsigned r;
        r   = $urandom_range(99);
        top = for_insert ? seen_len : ((seen_len > 0) ? seen_len - 1 : 0);
        if (r < 10)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (r < 20)
            return POS_W'(seen_len);
        return POS_W'($urandom_range(0, top));
    endfunction

    initial
    begin
        logic        growing;
        int unsigned hold;
        int unsigned r;
        logic [2:0]  op;

        foreach (issued[k])
            issued[k] = 0;
        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7FFF_FFFF;
        word_pool[2] = 32'h0000_0000;
        word_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 8; k++)
            word_pool[k] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every access is rejected
        issue(CMD_READ,   7'd0, 32'h0);
        issue(CMD_REMOVE, 7'd0, 32'h0);
        issue(CMD_SEARCH, 7'd0, 32'h0);
        issue(CMD_SPARE_5, 7'h7F, 32'hFFFF_FFFF);
        issue(CMD_SPARE_6, 7'd0, 32'h0);
        issue(CMD_SPARE_7, 7'h40, 32'h5A5A_5A5A);
        // value extremes
        issue(CMD_APPEND, 7'd0, 32'h7FFF_FFFF);
        issue(CMD_APPEND, 7'h7F, 32'h8000_0000);
        issue(CMD_APPEND, 7'd0, 32'h0000_0000);
        issue(CMD_APPEND, 7'd0, 32'hFFFF_FFFF);
        // insert at head, at the length (same as append), beyond the length
        issue(CMD_INSERT, 7'd0, 32'h5555_5555);
        issue(CMD_INSERT, 7'd5, 32'hAAAA_AAAA);
        issue(CMD_INSERT, 7'h7F, 32'h1234_5678);
        issue(CMD_INSERT, 7'd7, 32'h1234_5678);
        // duplicate so the first match must be reported
        issue(CMD_INSERT, 7'd2, 32'hFFFF_FFFF);
        issue(CMD_SEARCH, 7'd0, 32'hFFFF_FFFF);
        issue(CMD_SEARCH, 7'd0, 32'h8000_0000);
        issue(CMD_SEARCH, 7'd0, 32'h0000_3039);
        issue(CMD_READ,   7'd0, 32'h0);
        issue(CMD_READ,   7'd6, 32'h0);
        issue(CMD_READ,   7'h7F, 32'h0);
        issue(CMD_REMOVE, 7'd0, 32'h0);
        issue(CMD_REMOVE, 7'd5, 32'h0);
        issue(CMD_REMOVE, 7'h64, 32'h0);
        issue(CMD_READ,   7'd4, 32'h0);

        // random traffic: grow to full, linger, drain to empty, linger, repeat
        growing = 1'b1;
        hold    = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 400 && n < 650);
            if (growing && seen_len == DEPTH)
                hold++;
            else if (!growing && seen_len == 0)
                hold++;
            if (hold > 4 + $urandom_range(0, 4))
            begin
                growing = !growing;
                hold    = 0;
            end
            r = $urandom_range(99);
            if (growing)
                op = (r < 35) ? CMD_APPEND : (r < 65) ? CMD_INSERT :
                     (r < 73) ? CMD_REMOVE : (r < 85) ? CMD_SEARCH :
                     (r < 98) ? CMD_READ   : 3'(CMD_SPARE_5 + $urandom_range(0, 2));
            else
                op = (r < 8)  ? CMD_APPEND : (r < 18) ? CMD_INSERT :
                     (r < 70) ? CMD_REMOVE : (r < 84) ? CMD_SEARCH :
                     (r < 98) ? CMD_READ   : 3'(CMD_SPARE_5 + $urandom_range(0, 2));
            case (op)
                CMD_APPEND: issue(op, POS_W'($urandom), pick_word());
                CMD_INSERT: issue(op, pick_pos(1'b1), pick_word());
                CMD_SEARCH: issue(op, POS_W'($urandom), pick_word());
                default:    issue(op, pick_pos(1'b0), $urandom);
            endcase
        end
        no_idle = 1'b0;
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Items: %0d append, %0d insert, %0d remove, %0d search, %0d read, %0d spare",
                 issued[CMD_APPEND], issued[CMD_INSERT], issued[CMD_REMOVE],
                 issued[CMD_SEARCH], issued[CMD_READ],
                 issued[CMD_SPARE_5] + issued[CMD_SPARE_6] + issued[CMD_SPARE_7]);
        $display("Results: %0d checked, %0d rejected, %0d with list full, %0d with list empty",
                 n_done, n_rejected, n_full, n_empty);
        if (errors == 0 && outstanding == 0)
            $display("ordered_array_list regression: pass");
        else
            $display("ordered_array_list regression: fail");
        $finish;
    end

endmodule
